/* design/fld_pkg.sv */
// Shared types, codes and constants for the framed link byte deframer.
package fld_pkg;

    // Frame layout and buffer defaults
    localparam int HEADER_BYTES         = 4;
    localparam int BUFFER_BYTES_DEFAULT = 192;
    localparam logic [7:0] PAYLOAD_LIMIT_RESET = 8'd188;

    // Result queue between the parser and the output side
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_LW    = $clog2(QUEUE_DEPTH + 1);

    // Item actions
    typedef enum logic [1:0] {
        ACT_BYTE    = 2'd0,
        ACT_END     = 2'd1,
        ACT_READ    = 2'd2,
        ACT_RELEASE = 2'd3
    } action_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MAGIC   = 2'd0,
        CFG_TYPE_A  = 2'd1,
        CFG_TYPE_B  = 2'd2,
        CFG_LIMIT   = 2'd3
    } cfg_index_t;

    // Input word
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
        logic [7:0] read_index;
        logic [7:0] read_limit;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic       frame_ready;
        logic [7:0] frame_length;
        logic [7:0] read_data;
        logic [7:0] copied_count;
    } out_word_t;

    // Parser result waiting for the store read data
    typedef struct packed {
        logic       frame_ready;
        logic [7:0] frame_length;
        logic [7:0] copied_count;
        logic       read_hit;
    } desc_t;

    // Queue status back to the parser
    typedef struct packed {
        logic [QUEUE_LW-1:0] level;
    } back_status_t;

endpackage

/* design/fld_store.sv */
// Single-frame byte store: one write port, one registered read port.
module fld_store #(
    parameter int BUFFER_BYTES = fld_pkg::BUFFER_BYTES_DEFAULT,
    parameter int AW           = $clog2(BUFFER_BYTES)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] store_mem [BUFFER_BYTES];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/fld_front.sv */
// Front end: accepts words, holds config, runs the frame parser, drives the store.
module fld_front #(
    parameter int BUFFER_BYTES = fld_pkg::BUFFER_BYTES_DEFAULT,
    parameter int AW           = $clog2(BUFFER_BYTES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  fld_pkg::in_word_t    in_word,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  fld_pkg::back_status_t back_status,
    output logic                 store_wr_en,
    output logic [AW-1:0]        store_wr_addr,
    output logic [7:0]           store_wr_data,
    output logic                 store_rd_en,
    output logic [AW-1:0]        store_rd_addr,
    output logic                 desc_valid,
    output fld_pkg::desc_t       desc
);

    localparam logic [7:0] BUF_BYTES8 = 8'(BUFFER_BYTES);
    localparam logic [8:0] BUF_BYTES9 = 9'(BUFFER_BYTES);

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_TYPE    = 3'd1,
        PH_SEQ     = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    phase_t         phase_reg, phase_next;
    logic [7:0]     count_reg, count_next;
    logic [7:0]     expected_reg, expected_next;
    logic           ready_reg, ready_next;
    logic [7:0]     magic_reg, magic_next;
    logic [7:0]     type_a_reg, type_a_next;
    logic [7:0]     type_b_reg, type_b_next;
    logic [7:0]     limit_reg, limit_next;
    logic           desc_valid_reg, desc_valid_next;
    fld_pkg::desc_t desc_reg, desc_next;

    logic       accept;
    logic [8:0] total;
    logic [7:0] copied;
    logic       read_hit;
    logic       room;

    // Stall while the queue plus the word in flight would fill it
    assign full   = (32'(back_status.level) + 32'(desc_valid_reg)) >= fld_pkg::QUEUE_DEPTH;
    assign accept = push && !full;
    assign total  = {1'b0, in_word.data_byte} + 9'(fld_pkg::HEADER_BYTES);
    assign room   = count_reg < BUF_BYTES8;

    // Parser next state
    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        expected_next = expected_reg;
        ready_next    = ready_reg;
        magic_next    = magic_reg;
        type_a_next   = type_a_reg;
        type_b_next   = type_b_reg;
        limit_next    = limit_reg;
        store_wr_en   = 1'b0;
        store_wr_addr = count_reg[AW-1:0];
        store_wr_data = in_word.data_byte;
        copied        = 8'd0;
        read_hit      = 1'b0;

        // Config writes are to arrive only while idle; the block itself does not enforce it.
        if (cfg_wr_en)
        begin
            case (fld_pkg::cfg_index_t'(cfg_index))
                fld_pkg::CFG_MAGIC:  magic_next  = cfg_data;
                fld_pkg::CFG_TYPE_A: type_a_next = cfg_data;
                fld_pkg::CFG_TYPE_B: type_b_next = cfg_data;
                fld_pkg::CFG_LIMIT:  limit_next  = cfg_data;
                default:             limit_next  = limit_reg;
            endcase
        end

        if (accept)
        begin
            case (fld_pkg::action_t'(in_word.action))
                fld_pkg::ACT_BYTE:
                begin
                    if (!ready_reg)
                    begin
                        if (in_word.data_byte == magic_reg && phase_reg != PH_PAYLOAD)
                        begin
                            // magic restarts the header
                            store_wr_en   = 1'b1;
                            store_wr_addr = '0;
                            count_next    = 8'd1;
                            phase_next    = PH_TYPE;
                        end
                        else
                        begin
                            case (phase_reg)
                                PH_TYPE:
                                begin
                                    store_wr_en = room;
                                    count_next  = room ? count_reg + 8'd1 : count_reg;
                                    if (in_word.data_byte != type_a_reg &&
                                        in_word.data_byte != type_b_reg)
                                    begin
                                        count_next    = 8'd0;
                                        expected_next = 8'd0;
                                        phase_next    = PH_MAGIC;
                                    end
                                    else
                                    begin
                                        phase_next = PH_SEQ;
                                    end
                                end
                                PH_SEQ:
                                begin
                                    store_wr_en = room;
                                    count_next  = room ? count_reg + 8'd1 : count_reg;
                                    phase_next  = PH_LEN;
                                end
                                PH_LEN:
                                begin
                                    store_wr_en = room;
                                    count_next  = room ? count_reg + 8'd1 : count_reg;
                                    if (in_word.data_byte > limit_reg || total > BUF_BYTES9)
                                    begin
                                        count_next    = 8'd0;
                                        expected_next = 8'd0;
                                        phase_next    = PH_MAGIC;
                                    end
                                    else if (in_word.data_byte == 8'd0)
                                    begin
                                        // empty payload completes at once
                                        ready_next    = 1'b1;
                                        expected_next = 8'd0;
                                        phase_next    = PH_MAGIC;
                                    end
                                    else
                                    begin
                                        expected_next = total[7:0];
                                        phase_next    = PH_PAYLOAD;
                                    end
                                end
                                PH_PAYLOAD:
                                begin
                                    if (!room)
                                    begin
                                        count_next    = 8'd0;
                                        expected_next = 8'd0;
                                        phase_next    = PH_MAGIC;
                                    end
                                    else
                                    begin
                                        store_wr_en = 1'b1;
                                        count_next  = count_reg + 8'd1;
                                        if (expected_reg != 8'd0 &&
                                            (count_reg + 8'd1) >= expected_reg)
                                        begin
                                            ready_next    = 1'b1;
                                            expected_next = 8'd0;
                                            phase_next    = PH_MAGIC;
                                        end
                                    end
                                end
                                default:
                                begin
                                    // waiting for magic: byte ignored
                                    phase_next = PH_MAGIC;
                                end
                            endcase
                        end
                    end
                end
                fld_pkg::ACT_END:
                begin
                    if (!ready_reg)
                    begin
                        count_next    = 8'd0;
                        expected_next = 8'd0;
                        phase_next    = PH_MAGIC;
                    end
                end
                fld_pkg::ACT_READ:
                begin
                    read_hit = (in_word.read_index < count_reg) &&
                               (in_word.read_index < BUF_BYTES8);
                end
                fld_pkg::ACT_RELEASE:
                begin
                    if (ready_reg)
                    begin
                        copied        = (count_reg < in_word.read_limit) ?
                                        count_reg : in_word.read_limit;
                        ready_next    = 1'b0;
                        count_next    = 8'd0;
                        expected_next = 8'd0;
                        phase_next    = PH_MAGIC;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        desc_valid_next        = accept;
        desc_next.frame_ready  = ready_next;
        desc_next.frame_length = count_next;
        desc_next.copied_count = copied;
        desc_next.read_hit     = read_hit;
    end

    assign store_rd_en   = accept && (in_word.action == fld_pkg::ACT_READ);
    assign store_rd_addr = in_word.read_index[AW-1:0];

    // Parser state, config and descriptor stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MAGIC;
            count_reg      <= 8'd0;
            expected_reg   <= 8'd0;
            ready_reg      <= 1'b0;
            magic_reg      <= 8'd0;
            type_a_reg     <= 8'd0;
            type_b_reg     <= 8'd0;
            limit_reg      <= fld_pkg::PAYLOAD_LIMIT_RESET;
            desc_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            expected_reg   <= expected_next;
            ready_reg      <= ready_next;
            magic_reg      <= magic_next;
            type_a_reg     <= type_a_next;
            type_b_reg     <= type_b_next;
            limit_reg      <= limit_next;
            desc_valid_reg <= desc_valid_next;
        end
    end

    // Descriptor payload needs no reset
    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

    assign desc_valid = desc_valid_reg;
    assign desc       = desc_reg;

endmodule

/* design/fld_back.sv */
// Back end: merges store read data into results and queues them for the consumer.
module fld_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  desc_valid,
    input  fld_pkg::desc_t        desc,
    input  logic [7:0]            store_rd_data,
    output fld_pkg::back_status_t back_status,
    output logic                  empty,
    input  logic                  pop,
    output fld_pkg::out_word_t    out_word
);

    fld_pkg::out_word_t queue_mem [fld_pkg::QUEUE_DEPTH];

    logic [fld_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fld_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fld_pkg::QUEUE_LW-1:0] level_reg, level_next;

    fld_pkg::out_word_t result;
    logic               do_pop;

    // Build the result word
    always_comb
    begin
        result.frame_ready  = desc.frame_ready;
        result.frame_length = desc.frame_length;
        result.read_data    = desc.read_hit ? store_rd_data : 8'd0;
        result.copied_count = desc.copied_count;
    end

    assign empty  = (level_reg == '0);
    assign do_pop = pop && !empty;

    // Pointer and level update
    always_comb
    begin
        wr_ptr_next = desc_valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg + fld_pkg::QUEUE_LW'(desc_valid) -
                      fld_pkg::QUEUE_LW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (desc_valid)
        begin
            queue_mem[wr_ptr_reg] <= result;
        end
    end

    assign out_word          = queue_mem[rd_ptr_reg];
    assign back_status.level = level_reg;

endmodule

/* design/framed_link_byte_deframer_top.sv */
// Each result passes the descriptor register, then the result queue, to the output ports.
// Throughput: one word per cycle unless full; parser state updates in the accept cycle.
// full rises when the four-entry result queue plus the word in flight would fill it.
// Reset (rst_n, async, active low) clears parser state, queue and config to defaults.
// Frame store contents are not initialised; only bytes of the current frame are read.
module framed_link_byte_deframer_top #(
    parameter int BUFFER_BYTES = fld_pkg::BUFFER_BYTES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  fld_pkg::in_word_t  in_word,
    output logic               empty,
    input  logic               pop,
    output fld_pkg::out_word_t out_word,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    localparam int AW = $clog2(BUFFER_BYTES);

    logic                  store_wr_en;
    logic [AW-1:0]         store_wr_addr;
    logic [7:0]            store_wr_data;
    logic                  store_rd_en;
    logic [AW-1:0]         store_rd_addr;
    logic [7:0]            store_rd_data;
    logic                  desc_valid;
    fld_pkg::desc_t        desc;
    fld_pkg::back_status_t back_status;

    // Parser front end
    fld_front #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .AW           (AW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_word       (in_word),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .back_status   (back_status),
        .store_wr_en   (store_wr_en),
        .store_wr_addr (store_wr_addr),
        .store_wr_data (store_wr_data),
        .store_rd_en   (store_rd_en),
        .store_rd_addr (store_rd_addr),
        .desc_valid    (desc_valid),
        .desc          (desc)
    );

    // Frame store
    fld_store #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .AW           (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_wr_en),
        .wr_addr (store_wr_addr),
        .wr_data (store_wr_data),
        .rd_en   (store_rd_en),
        .rd_addr (store_rd_addr),
        .rd_data (store_rd_data)
    );

    // Result queue
    fld_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .desc_valid    (desc_valid),
        .desc          (desc),
        .store_rd_data (store_rd_data),
        .back_status   (back_status),
        .empty         (empty),
        .pop           (pop),
        .out_word      (out_word)
    );

endmodule
